>>> hw/rtl/wsd_pkg.sv
// Shared types and constants for the weighted stock draw block.
`default_nettype none

package wsd_pkg;

  // Stream widths (fixed by the item layout)
  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 8;

  // Item kinds carried on s_tuser
  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_DRAW   = 2'd1,
    KIND_RETURN = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_BAD_INDEX = 2'd3
  } stat_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_RET_RD,
    ST_RET_WR,
    ST_SUM,
    ST_MUL,
    ST_PICK,
    ST_DEC,
    ST_CLEAR,
    ST_RESP
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // capture input fields
    logic do_add;      // append entry or flag full
    logic ret_chk;     // check return index, read its stock
    logic ret_wr;      // write incremented stock
    logic scan_start;  // rewind table scan and clear accumulator
    logic sum_en;      // scan pass that totals candidate weights
    logic mul_start;   // start fraction times total
    logic mul_en;      // one shift-add step
    logic pick_en;     // scan pass that builds running sum and compares
    logic dec_wr;      // take one from picked entry stock
    logic do_clear;    // empty the table
    logic set_none;    // result: nothing in stock
    logic out_load;    // move result into output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic ret_bad;     // return index at or beyond entry count
    logic scan_done;   // scan finished, no read in flight
    logic total_zero;  // no candidate weight
    logic mul_last;    // final multiply step this cycle
    logic hit;         // current entry satisfies the pick rule
  } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/weighted_stock_draw.sv
// A draw sums candidate weights, then, if nonzero, runs F = min(16, RAND_BITS)
// multiply steps and a pick scan; a return writes the stock unless the index is bad.
// Throughput: one item at a time; the next is taken once the controller is idle,
// set by the two table scans (one memory read per cycle) and the shift-add multiply.
// A finished result waits in the output register while the next item is accepted.
// Reset (rst, synchronous) empties the table and drops any pending result.
`default_nettype none

module weighted_stock_draw
  import wsd_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int WEIGHT_BITS = 16,
  parameter int RAND_BITS   = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // [15:0] weight, [31:16] rand_fraction, [35:32] entry_index, [39:36] zero
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  // [1:0] kind
  input  wire logic [S_TUSER_W-1:0] s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // [0] found, [4:1] picked_index, [6:5] status, [7] zero
  output logic      [M_TDATA_W-1:0] m_tdata
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  wsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Tables and arithmetic
  wsd_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .WEIGHT_BITS (WEIGHT_BITS),
    .RAND_BITS   (RAND_BITS)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule

`default_nettype wire

>>> hw/rtl/wsd_ctrl.sv
// Controller state machine for the weighted stock draw block.
`default_nettype none

module wsd_ctrl
  import wsd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TUSER_W-1:0] s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output cmd_t                      cmd,
  input  wire sts_t                 sts
);

  state_t state;
  state_t state_next;
  logic   out_free;
  kind_t  kind_in;

  assign out_free = !m_tvalid || m_tready;
  assign kind_in  = kind_t'(s_tuser);
  assign s_tready = (state == ST_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          case (kind_in)
            KIND_ADD:    state_next = ST_ADD;
            KIND_DRAW: begin
              cmd.scan_start = 1'b1;
              state_next     = ST_SUM;
            end
            KIND_RETURN: state_next = ST_RET_RD;
            KIND_CLEAR:  state_next = ST_CLEAR;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        cmd.do_add = 1'b1;
        state_next = ST_RESP;
      end
      ST_RET_RD: begin
        cmd.ret_chk = 1'b1;
        state_next  = sts.ret_bad ? ST_RESP : ST_RET_WR;
      end
      ST_RET_WR: begin
        cmd.ret_wr = 1'b1;
        state_next = ST_RESP;
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        if (sts.scan_done) begin
          if (sts.total_zero) begin
            cmd.set_none = 1'b1;
            state_next   = ST_RESP;
          end else begin
            cmd.mul_start = 1'b1;
            state_next    = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        if (sts.mul_last) begin
          cmd.scan_start = 1'b1;
          state_next     = ST_PICK;
        end
      end
      ST_PICK: begin
        cmd.pick_en = 1'b1;
        if (sts.hit) begin
          state_next = ST_DEC;
        end else if (sts.scan_done) begin
          cmd.set_none = 1'b1;
          state_next   = ST_RESP;
        end
      end
      ST_DEC: begin
        cmd.dec_wr = 1'b1;
        state_next = ST_RESP;
      end
      ST_CLEAR: begin
        cmd.do_clear = 1'b1;
        state_next   = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output valid: set on load, drop when the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // A result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending one");

  // Multiply runs until its last step
  a_mul_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL && !sts.mul_last) |=> (state == ST_MUL))
    else $error("multiply left early");

endmodule

`default_nettype wire

>>> hw/rtl/wsd_dpath.sv
// Datapath for the weighted stock draw block: tables, scan, multiply, result.
`default_nettype none

module wsd_dpath
  import wsd_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int WEIGHT_BITS = 16,
  parameter int RAND_BITS   = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  output logic      [M_TDATA_W-1:0] m_tdata,
  input  wire cmd_t                 cmd,
  output sts_t                      sts
);

  localparam int AW   = $clog2(MAX_ENTRIES);
  localparam int CNTW = $clog2(MAX_ENTRIES + 1);
  localparam int TW   = WEIGHT_BITS + AW;
  localparam int FW   = (RAND_BITS < 16) ? RAND_BITS : 16;
  localparam int MCW  = $clog2(FW);
  localparam int CW   = TW + RAND_BITS;
  localparam int XW   = (CNTW > 4) ? CNTW : 4;
  localparam logic [CNTW-1:0] MAX_CNT   = CNTW'(MAX_ENTRIES);
  localparam logic [MCW-1:0]  MUL_STEPS = MCW'(FW - 1);
  localparam logic [7:0]      STOCK_MAX = 8'hFF;

  // Tables
  logic [WEIGHT_BITS-1:0] weight_mem [MAX_ENTRIES];
  logic [7:0]             stock_mem  [MAX_ENTRIES];

  // Captured item
  logic [WEIGHT_BITS-1:0] weight_q;
  logic [FW-1:0]          frac_q;
  logic [3:0]             idx_q;

  logic [CNTW-1:0]        entry_count;

  // Scan state
  logic [CNTW-1:0]        ptr;
  logic                   rd_vld;
  logic [AW-1:0]          rd_idx;
  logic [WEIGHT_BITS-1:0] w_rd;
  logic [7:0]             s_rd;
  logic [TW-1:0]          total;
  logic [TW-1:0]          cum;
  logic [CW-1:0]          prod;
  logic [MCW-1:0]         mcnt;
  logic [AW-1:0]          pick_idx;
  logic [7:0]             pick_stock;

  // Pending and output results
  logic                   res_found;
  logic [3:0]             res_pick;
  stat_t                  res_status;
  logic                   out_found;
  logic [3:0]             out_pick;
  stat_t                  out_status;

  // Combinational helpers
  logic                   issue;
  logic                   cand;
  logic [TW-1:0]          cum_new;
  logic                   hit;
  logic                   full;
  logic [AW-1:0]          ret_addr;
  logic [AW-1:0]          s_addr;
  logic                   s_we;
  logic [AW-1:0]          s_waddr;
  logic [7:0]             s_wdata;

  assign issue    = (cmd.sum_en || cmd.pick_en) && (ptr < entry_count);
  assign cand     = rd_vld && (s_rd != 8'd0) && (w_rd != '0);
  assign cum_new  = cum + TW'(w_rd);
  assign hit      = cmd.pick_en && cand && (prod <= {cum_new, {RAND_BITS{1'b0}}});
  assign full     = (entry_count == MAX_CNT);
  assign ret_addr = AW'(idx_q);
  assign s_addr   = cmd.ret_chk ? ret_addr : ptr[AW-1:0];

  assign sts.ret_bad    = (XW'(idx_q) >= XW'(entry_count));
  assign sts.scan_done  = (ptr >= entry_count) && !rd_vld;
  assign sts.total_zero = (total == '0);
  assign sts.mul_last   = (mcnt == '0);
  assign sts.hit        = hit;

  // Select the single stock write
  always_comb begin
    s_we    = 1'b0;
    s_waddr = entry_count[AW-1:0];
    s_wdata = 8'd1;
    if (cmd.do_add && !full) begin
      s_we = 1'b1;
    end else if (cmd.ret_wr) begin
      s_we    = 1'b1;
      s_waddr = ret_addr;
      s_wdata = (s_rd == STOCK_MAX) ? s_rd : s_rd + 8'd1;
    end else if (cmd.dec_wr) begin
      s_we    = 1'b1;
      s_waddr = pick_idx;
      s_wdata = pick_stock - 8'd1;
    end
  end

  // Weight table: write on add, registered read at scan pointer
  always_ff @(posedge clk) begin
    if (cmd.do_add && !full) begin
      weight_mem[entry_count[AW-1:0]] <= weight_q;
    end
    w_rd <= weight_mem[ptr[AW-1:0]];
  end

  // Stock table: one write port, registered read
  always_ff @(posedge clk) begin
    if (s_we) begin
      stock_mem[s_waddr] <= s_wdata;
    end
    s_rd <= stock_mem[s_addr];
  end

  // Capture item fields on acceptance
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      weight_q <= WEIGHT_BITS'(s_tdata[15:0]);
      idx_q    <= s_tdata[35:32];
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.do_clear) begin
      entry_count <= '0;
    end else if (cmd.do_add && !full) begin
      entry_count <= entry_count + CNTW'(1);
    end
  end

  // Scan pointer and read-valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (cmd.scan_start) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      ptr <= '0;
    end else if (issue) begin
      ptr    <= ptr + CNTW'(1);
      rd_idx <= ptr[AW-1:0];
    end
  end

  // Accumulate candidate weights: total in the first pass, running sum in the second
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      cum <= '0;
      if (!cmd.mul_en) begin
        total <= '0;
      end
    end else begin
      if (cmd.sum_en && cand) begin
        total <= total + TW'(w_rd);
      end
      if (cmd.pick_en && cand) begin
        cum <= cum_new;
      end
    end
  end

  // Shift-add multiply of fraction by total, fraction MSB first
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frac_q <= FW'(s_tdata[31:16]);
    end else if (cmd.mul_en) begin
      frac_q <= {frac_q[FW-2:0], 1'b0};
    end
    if (cmd.mul_start) begin
      prod <= '0;
      mcnt <= MUL_STEPS;
    end else if (cmd.mul_en) begin
      prod <= {prod[CW-2:0], 1'b0} + (frac_q[FW-1] ? CW'(total) : '0);
      mcnt <= mcnt - MCW'(1);
    end
  end

  // Record the pick
  always_ff @(posedge clk) begin
    if (hit) begin
      pick_idx   <= rd_idx;
      pick_stock <= s_rd;
    end
  end

  // Build the pending result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_found  <= 1'b0;
      res_pick   <= 4'd0;
      res_status <= STAT_OK;
    end else if (cmd.do_add) begin
      if (full) begin
        res_status <= STAT_FULL;
      end else begin
        res_pick <= 4'(entry_count);
      end
    end else if (cmd.ret_chk && sts.ret_bad) begin
      res_status <= STAT_BAD_INDEX;
    end else if (cmd.ret_wr) begin
      res_pick <= idx_q;
    end else if (cmd.set_none) begin
      res_status <= STAT_EMPTY;
    end else if (cmd.dec_wr) begin
      res_found <= 1'b1;
      res_pick  <= 4'(pick_idx);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found  <= res_found;
      out_pick   <= res_pick;
      out_status <= res_status;
    end
  end

  assign m_tdata = {1'b0, out_status, out_pick, out_found};

  // Entry count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= MAX_CNT)
    else $error("entry count beyond table size");

  // A pick is always followed by the stock decrement
  a_hit_dec: assert property (@(posedge clk) disable iff (rst)
    hit |=> cmd.dec_wr)
    else $error("pick without stock decrement");

endmodule

`default_nettype wire

>>> tb/wsd_result_checker.sv
// Checker for the weighted stock draw block: predicts each result and compares it.
module wsd_result_checker
  import wsd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  input  wire logic                 s_tready,
  // [15:0] weight, [31:16] rand_fraction, [35:32] entry_index, [39:36] zero
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  // [1:0] kind
  input  wire logic [S_TUSER_W-1:0] s_tuser,
  input  wire logic                 m_tvalid,
  input  wire logic                 m_tready,
  // [0] found, [4:1] picked_index, [6:5] status, [7] zero
  input  wire logic [M_TDATA_W-1:0] m_tdata,
  output int unsigned               fail_count,
  output int unsigned               pending
);

  localparam int TABLE_DEPTH = 16;

  typedef struct {
    logic       found;
    logic [3:0] idx;
    stat_t      status;
  } outcome_t;

  // Shadow copy of the block's table
  logic [15:0] wt_tab    [TABLE_DEPTH];
  logic [7:0]  stock_tab [TABLE_DEPTH];
  int          n_entries;

  outcome_t outcome_q [$];

  // Apply one item to the shadow table and return the outcome it should give
  function automatic outcome_t apply_stock_item(kind_t kind, logic [15:0] wt,
                                                logic [15:0] frac, logic [3:0] idx);
    outcome_t    res;
    logic [63:0] total;
    logic [63:0] cum;
    logic [63:0] target;
    res = '{found: 1'b0, idx: 4'd0, status: STAT_OK};
    case (kind)
      KIND_ADD: begin
        if (n_entries >= TABLE_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          wt_tab[n_entries]    = wt;
          stock_tab[n_entries] = 8'd1;
          res.idx              = n_entries[3:0];
          n_entries++;
        end
      end
      KIND_DRAW: begin
        total = '0;
        cum   = '0;
        for (int i = 0; i < n_entries; i++)
          if (stock_tab[i] != 8'd0 && wt_tab[i] != 16'd0) total += wt_tab[i];
        res.status = STAT_EMPTY;
        target     = 64'(frac) * total;
        // Walk the running sum; first candidate that covers the fraction wins
        if (total != 0) begin
          for (int i = 0; i < n_entries; i++) begin
            if (!res.found && stock_tab[i] != 8'd0 && wt_tab[i] != 16'd0) begin
              cum += wt_tab[i];
              if (target <= (cum << 16)) begin
                stock_tab[i]--;
                res.found  = 1'b1;
                res.idx    = 4'(i);
                res.status = STAT_OK;
              end
            end
          end
        end
      end
      KIND_RETURN: begin
        if (int'(idx) >= n_entries) begin
          res.status = STAT_BAD_INDEX;
        end else begin
          // Stock saturates at its top value
          if (stock_tab[idx] != 8'hFF) stock_tab[idx]++;
          res.idx = idx;
        end
      end
      default: n_entries = 0;
    endcase
    return res;
  endfunction

  // Predict on each accepted item, compare on each accepted result
  always @(posedge clk) begin
    outcome_t    want;
    outcome_t    fresh;
    logic        got_found;
    logic [3:0]  got_idx;
    stat_t       got_status;
    int unsigned n_bad;
    n_bad = 0;
    if (rst) begin
      n_entries = 0;
      outcome_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        fresh = apply_stock_item(kind_t'(s_tuser[1:0]), s_tdata[15:0],
                                 s_tdata[31:16], s_tdata[35:32]);
        outcome_q.insert(outcome_q.size(), fresh);
      end
      if (m_tvalid && m_tready) begin
        got_found  = m_tdata[0];
        got_idx    = m_tdata[4:1];
        got_status = stat_t'(m_tdata[6:5]);
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual 0x%02h", $time, m_tdata);
          n_bad++;
        end else begin
          want = outcome_q.pop_front();
          if (got_found !== want.found) begin
            $display("%0t: found mismatch, expected %0b, actual %0b",
                     $time, want.found, got_found);
            n_bad++;
          end
          if (got_idx !== want.idx) begin
            $display("%0t: picked_index mismatch, expected %0d, actual %0d",
                     $time, want.idx, got_idx);
            n_bad++;
          end
          if (got_status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got_status);
            n_bad++;
          end
        end
      end
      fail_count <= fail_count + n_bad;
      pending    <= outcome_q.size();
    end
  end

endmodule

>>> tb/tb_weighted_stock_draw.sv
// Testbench top for the weighted stock draw block: clock, reset, stimulus and verdict.
module tb_weighted_stock_draw;
  import wsd_pkg::*;

  localparam int RANDOM_ITEMS = 140;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // [15:0] weight, [31:16] rand_fraction, [35:32] entry_index, [39:36] zero
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  // [1:0] kind
  logic [S_TUSER_W-1:0] s_tuser  = KIND_ADD;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // [0] found, [4:1] picked_index, [6:5] status, [7] zero
  logic [M_TDATA_W-1:0] m_tdata;

  int unsigned fail_count;
  int unsigned pending;

  bit          src_steady  = 1'b0;
  bit          sink_steady = 1'b0;
  int          tbl_n;
  int          n_rand;
  int unsigned sink_hold;

  always #10 clk = ~clk;

  weighted_stock_draw i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  wsd_result_checker i_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_weight();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    if (r < 4)  return 16'($urandom_range(1, 15));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_frac();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Random back-pressure on the result side
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      sink_hold = 0;
    end else if (sink_steady) begin
      m_tready <= 1'b1;
    end else if (sink_hold != 0) begin
      sink_hold--;
    end else if (m_tready) begin
      m_tready  <= 1'b0;
      sink_hold = idle_len();
    end else begin
      m_tready  <= 1'b1;
      sink_hold = $urandom_range(0, 8);
    end
  end

  // Offer one item after an optional gap and hold it until the transaction
  task automatic send_item(kind_t kind, logic [15:0] wt, logic [15:0] frac, logic [3:0] idx);
    int unsigned gap;
    gap = src_steady ? 0 : idle_len();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {4'b0000, idx, frac, wt};
    do @(posedge clk); while (!s_tready);
    if (kind == KIND_CLEAR) tbl_n = 0;
    else if (kind == KIND_ADD && tbl_n < 16) tbl_n++;
  endtask

  // Stop sending and hold until every expected result has come
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int unsigned r;
    int unsigned n_ops;
    int unsigned n_add;
    logic [3:0]  ix;
    tbl_n  = 0;
    n_rand = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table: draw finds nothing, return hits a bad index
    send_item(KIND_DRAW,   16'h1234, 16'h8000, 4'd0);
    send_item(KIND_RETURN, 16'h0000, 16'h0000, 4'd0);
    send_item(KIND_CLEAR,  16'hFFFF, 16'hFFFF, 4'hF);
    // Zero weight, max weight, unit weight
    send_item(KIND_ADD,    16'h0000, 16'hFFFF, 4'hF);
    send_item(KIND_ADD,    16'hFFFF, 16'h0000, 4'h0);
    send_item(KIND_ADD,    16'h0001, 16'h5555, 4'hA);
    // Fraction extremes; zero-weight entry never picked, then none left
    send_item(KIND_DRAW,   16'hFFFF, 16'h0000, 4'hF);
    send_item(KIND_DRAW,   16'h0000, 16'hFFFF, 4'h0);
    send_item(KIND_DRAW,   16'hAAAA, 16'h8000, 4'h5);
    // Returns: valid, far beyond, just at the entry count
    send_item(KIND_RETURN, 16'h0000, 16'h0000, 4'd1);
    send_item(KIND_RETURN, 16'hFFFF, 16'hFFFF, 4'd15);
    send_item(KIND_RETURN, 16'h0000, 16'h0000, 4'd3);
    send_item(KIND_DRAW,   16'h0000, 16'hFFFF, 4'h0);
    // Fill the table, then overflow it
    for (int i = 3; i < 16; i++)
      send_item(KIND_ADD, 16'(1 << i) | 16'(i), 16'($urandom), 4'(i));
    send_item(KIND_ADD,    16'h7777, 16'h0000, 4'h0);
    send_item(KIND_DRAW,   16'h0000, 16'hFFFF, 4'h0);
    send_item(KIND_RETURN, 16'h0000, 16'h0000, 4'd15);
    drain_results();

    // Drive one entry's stock into saturation and draw around it
    src_steady  = 1'b1;
    sink_steady <= 1'b1;
    repeat (260) send_item(KIND_RETURN, 16'($urandom), 16'($urandom), 4'd15);
    repeat (4) send_item(KIND_DRAW, 16'($urandom), pick_frac(), 4'($urandom));
    send_item(KIND_RETURN, 16'($urandom), 16'($urandom), 4'd15);
    drain_results();

    // Random phases: build a table, then mix draws, returns and the odd add or clear
    while (n_rand < RANDOM_ITEMS) begin
      src_steady  = ($urandom_range(0, 5) == 0);
      sink_steady <= ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 3) != 0) begin
        send_item(KIND_CLEAR, 16'($urandom), 16'($urandom), 4'($urandom));
        n_rand++;
      end
      n_add = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 6);
      repeat (n_add) begin
        send_item(KIND_ADD, pick_weight(), 16'($urandom), 4'($urandom));
        n_rand++;
      end
      n_ops = $urandom_range(10, 40);
      repeat (n_ops) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          send_item(KIND_DRAW, 16'($urandom), pick_frac(), 4'($urandom));
        end else if (r < 78) begin
          if (tbl_n > 0 && $urandom_range(0, 9) != 0) ix = 4'($urandom_range(0, tbl_n - 1));
          else ix = 4'($urandom);
          send_item(KIND_RETURN, 16'($urandom), 16'($urandom), ix);
        end else if (r < 92) begin
          send_item(KIND_ADD, pick_weight(), 16'($urandom), 4'($urandom));
        end else if (r < 95) begin
          send_item(KIND_CLEAR, 16'($urandom), 16'($urandom), 4'($urandom));
        end else begin
          send_item(KIND_RETURN, 16'($urandom), 16'($urandom), 4'($urandom));
        end
        n_rand++;
      end
      if ($urandom_range(0, 2) == 0) drain_results();
    end

    // Wind down and give the verdict
    sink_steady <= 1'b0;
    drain_results();
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("weighted_stock_draw test passed");
    end else begin
      $display("weighted_stock_draw test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("weighted_stock_draw test failed");
    $finish;
  end

endmodule
